>>> rtl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge outside reset.
`define NWW_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("nww assertion failed");

// Condition must never be true outside reset.
`define NWW_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("nww forbidden condition seen");

`else

`define NWW_ASSERT(lbl, ck, rn, prop)
`define NWW_ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

>>> rtl/nww_pkg.sv
`timescale 1ns / 1ps

package nww_pkg;

    localparam int MAX_POINTS = 256;
    localparam int MAX_WINDOW = 32;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W   = $clog2(MAX_POINTS + 1);
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int WSEL_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int COORD_W   = 32;
    localparam int DIST_W    = 2 * COORD_W + 1;
    localparam int OUT_IDX_W = 8;
    localparam int CFG_W     = 6;
    localparam int KIND_W    = 2;
    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_DATA_W = 2 * COORD_W + OUT_IDX_W;

    localparam logic [CFG_W-1:0] WL_RESET = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic capture;
        logic shift;
    } cell_ctl_t;

endpackage

>>> rtl/nearest_waypoint_window.sv
`timescale 1ns / 1ps
// Path-point table with a nearest-point query. Clear and append requests leave the block
// idle and ready for the next request. A query on a table of N points scans all N of them.
// The scan reads one point per cycle through the single read port of the point RAM into a
// four-stage read and distance pipeline. It then emits the points one at a time (up to
// window_length of them, zero meaning one, at most 32) as the output side takes them. A
// query on an empty table returns its single none_found result in the next cycle. During
// the scan every point is compared with the best so far. The points from the current best
// onward are caught in a row of window cells, which then shift out the results.
// No request is taken while a query is scanning or emitting.

`include "assert_macros.svh"

module nearest_waypoint_window (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: window_length
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nww_pkg::CFG_W-1:0]          cfg_data,
    // requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nww_pkg::IN_DATA_W-1:0]      s_tdata,   // pos_x[31:0], pos_y[63:32]
    input  logic [nww_pkg::KIND_W-1:0]         s_tuser,   // kind[1:0]
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nww_pkg::OUT_DATA_W-1:0]     m_tdata,   // point_x[31:0], point_y[63:32],
                                                          // point_index[71:64]
    output logic [0:0]                         m_tuser,   // none_found[0]
    output logic                               m_tlast
);

    localparam int CW = nww_pkg::COORD_W;
    localparam logic [nww_pkg::COUNT_W-1:0] COUNT_FULL =
        nww_pkg::COUNT_W'(nww_pkg::MAX_POINTS);

    nww_pkg::state_t state_reg, state_next;
    logic [nww_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [nww_pkg::COUNT_W-1:0] issue_reg, issue_next;
    logic [nww_pkg::CFG_W-1:0]   wl_reg, wl_next;
    logic [nww_pkg::WIN_W-1:0]   fill_reg, fill_next;
    logic [nww_pkg::WIN_W-1:0]   remain_reg, remain_next;
    logic                        none_reg, none_next;
    nww_pkg::tag_t               rd_tag_reg, rd_tag_next;
    logic [nww_pkg::IDX_W-1:0]   rd_idx_reg;
    logic signed [CW-1:0]        qx_reg, qy_reg;
    logic [nww_pkg::DIST_W-1:0]  best_dist_reg;

    logic                        s_accept, m_accept;
    logic                        ram_we;
    logic [2*CW-1:0]             ram_rdata;
    logic                        issue_ok;
    logic [nww_pkg::WIN_W-1:0]   win_eff;

    nww_pkg::point_t             rd_pt;
    nww_pkg::tag_t               dist_tag;
    nww_pkg::point_t             dist_pt;
    logic [nww_pkg::DIST_W-1:0]  dist_val;

    logic                        new_best, cap_en, emit_shift;
    logic [nww_pkg::WSEL_W-1:0]  cap_sel;
    nww_pkg::point_t             cell_pt [nww_pkg::MAX_WINDOW];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == nww_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == nww_pkg::ST_EMIT);
    assign m_accept  = m_tvalid && m_tready;

    // window length: zero means one, saturate at the row length
    always_comb
    begin
        if (wl_reg == '0)
        begin
            win_eff = nww_pkg::WIN_W'(1);
        end
        else if (int'(wl_reg) > nww_pkg::MAX_WINDOW)
        begin
            win_eff = nww_pkg::WIN_W'(nww_pkg::MAX_WINDOW);
        end
        else
        begin
            win_eff = nww_pkg::WIN_W'(wl_reg);
        end
    end

    assign ram_we = s_accept && (s_tuser == nww_pkg::KIND_APPEND) && (count_reg < COUNT_FULL);

    nww_ram #(
        .WIDTH (2 * CW),
        .DEPTH (nww_pkg::MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[nww_pkg::IDX_W-1:0]),
        .wdata (s_tdata),
        .raddr (issue_reg[nww_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign issue_ok = (state_reg == nww_pkg::ST_SCAN) && (issue_reg < count_reg);

    always_comb
    begin
        rd_tag_next.valid = issue_ok;
        rd_tag_next.last  = (issue_reg + nww_pkg::COUNT_W'(1)) == count_reg;
        rd_pt.idx = rd_idx_reg;
        rd_pt.x   = ram_rdata[CW-1:0];
        rd_pt.y   = ram_rdata[2*CW-1:CW];
    end

    nww_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (rd_tag_reg),
        .in_pt    (rd_pt),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .out_tag  (dist_tag),
        .out_pt   (dist_pt),
        .out_dist (dist_val)
    );

    // strict compare in scan order keeps the lowest index on a tie
    assign new_best = (dist_pt.idx == '0) || (dist_val < best_dist_reg);
    assign cap_en   = dist_tag.valid && (new_best || (fill_reg < win_eff));
    assign cap_sel  = new_best ? '0 : fill_reg[nww_pkg::WSEL_W-1:0];
    assign emit_shift = m_accept;

    always_comb
    begin
        fill_next = fill_reg;
        if (dist_tag.valid)
        begin
            if (new_best)
            begin
                fill_next = nww_pkg::WIN_W'(1);
            end
            else if (fill_reg < win_eff)
            begin
                fill_next = fill_reg + nww_pkg::WIN_W'(1);
            end
        end
        else if (s_accept)
        begin
            fill_next = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        remain_next = remain_reg;
        none_next   = none_reg;
        wl_next     = wl_reg;

        if (cfg_valid && cfg_ready)
        begin
            wl_next = cfg_data;
        end

        case (state_reg)
            nww_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_tuser)
                        nww_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        nww_pkg::KIND_APPEND:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + nww_pkg::COUNT_W'(1);
                            end
                        end
                        nww_pkg::KIND_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next  = nww_pkg::ST_EMIT;
                                remain_next = nww_pkg::WIN_W'(1);
                                none_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = nww_pkg::ST_SCAN;
                                issue_next = '0;
                                none_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            // drop the request
                        end
                    endcase
                end
            end
            nww_pkg::ST_SCAN:
            begin
                if (issue_ok)
                begin
                    issue_next = issue_reg + nww_pkg::COUNT_W'(1);
                end
                if (dist_tag.valid && dist_tag.last)
                begin
                    state_next  = nww_pkg::ST_EMIT;
                    remain_next = fill_next;
                end
            end
            nww_pkg::ST_EMIT:
            begin
                if (m_accept)
                begin
                    if (remain_reg == nww_pkg::WIN_W'(1))
                    begin
                        state_next = nww_pkg::ST_IDLE;
                    end
                    remain_next = remain_reg - nww_pkg::WIN_W'(1);
                end
            end
            default:
            begin
                state_next = nww_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nww_pkg::ST_IDLE;
            count_reg  <= '0;
            issue_reg  <= '0;
            wl_reg     <= nww_pkg::WL_RESET;
            fill_reg   <= '0;
            remain_reg <= '0;
            none_reg   <= 1'b0;
            rd_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            wl_reg     <= wl_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            none_reg   <= none_next;
            rd_tag_reg <= rd_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= issue_reg[nww_pkg::IDX_W-1:0];
        if (s_accept && (s_tuser == nww_pkg::KIND_QUERY))
        begin
            qx_reg <= s_tdata[CW-1:0];
            qy_reg <= s_tdata[2*CW-1:CW];
        end
        if (dist_tag.valid && new_best)
        begin
            best_dist_reg <= dist_val;
        end
    end

    // window row: capture from the compare stage, shift toward cell 0 on each result
    for (genvar k = 0; k < nww_pkg::MAX_WINDOW; k++)
    begin : g_cell
        nww_pkg::cell_ctl_t ctl;
        nww_pkg::point_t    nbr;

        assign ctl = '{capture: cap_en && (cap_sel == nww_pkg::WSEL_W'(k)),
                       shift: emit_shift};

        if (k == nww_pkg::MAX_WINDOW - 1)
        begin : g_end
            assign nbr = cell_pt[k];
        end
        else
        begin : g_mid
            assign nbr = cell_pt[k+1];
        end

        nww_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .stream_pt (dist_pt),
            .nbr_pt    (nbr),
            .pt        (cell_pt[k])
        );
    end

    assign m_tdata = none_reg ? '0 :
                     {nww_pkg::OUT_IDX_W'(cell_pt[0].idx), cell_pt[0].y, cell_pt[0].x};
    assign m_tuser = none_reg;
    assign m_tlast = (remain_reg == nww_pkg::WIN_W'(1));

    `NWW_ASSERT(a_last_ends_run, clk, rst_n, (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    `NWW_ASSERT(a_none_is_last, clk, rst_n, (m_tvalid && m_tuser[0]) |-> m_tlast)
    `NWW_ASSERT(a_dist_in_scan, clk, rst_n, dist_tag.valid |-> (state_reg == nww_pkg::ST_SCAN))
    `NWW_ASSERT(a_run_bound, clk, rst_n, m_tvalid |-> (remain_reg != 0 && remain_reg <= win_eff))
    `NWW_ASSERT_NEVER(a_fill_over, clk, rst_n, fill_reg > win_eff && state_reg == nww_pkg::ST_SCAN)

endmodule

>>> rtl/nww_ram.sv
`timescale 1ns / 1ps

module nww_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nww_dist.sv
`timescale 1ns / 1ps

module nww_dist (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  nww_pkg::tag_t                          in_tag,
    input  nww_pkg::point_t                        in_pt,
    input  logic signed [nww_pkg::COORD_W-1:0]     qx,
    input  logic signed [nww_pkg::COORD_W-1:0]     qy,
    output nww_pkg::tag_t                          out_tag,
    output nww_pkg::point_t                        out_pt,
    output logic [nww_pkg::DIST_W-1:0]             out_dist
);

    localparam int CW = nww_pkg::COORD_W;

    logic [CW:0]        dx_a, dx_b, dy_a, dy_b;
    logic [CW-1:0]      magx_next, magy_next;
    logic [2*CW-1:0]    sqx_next, sqy_next;
    logic [nww_pkg::DIST_W-1:0] dist_next;

    nww_pkg::tag_t   tag_a_reg, tag_b_reg, tag_c_reg;
    nww_pkg::point_t pt_a_reg, pt_b_reg, pt_c_reg;
    logic [CW-1:0]   magx_reg, magy_reg;
    logic [2*CW-1:0] sqx_reg, sqy_reg;
    logic [nww_pkg::DIST_W-1:0] dist_reg;

    // both differences in parallel, pick the non-negative one
    assign dx_a = {in_pt.x[CW-1], in_pt.x} - {qx[CW-1], qx};
    assign dx_b = {qx[CW-1], qx} - {in_pt.x[CW-1], in_pt.x};
    assign dy_a = {in_pt.y[CW-1], in_pt.y} - {qy[CW-1], qy};
    assign dy_b = {qy[CW-1], qy} - {in_pt.y[CW-1], in_pt.y};

    assign magx_next = dx_a[CW] ? dx_b[CW-1:0] : dx_a[CW-1:0];
    assign magy_next = dy_a[CW] ? dy_b[CW-1:0] : dy_a[CW-1:0];

    assign sqx_next = magx_reg * magx_reg;
    assign sqy_next = magy_reg * magy_reg;

    assign dist_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_a_reg <= in_pt;
        magx_reg <= magx_next;
        magy_reg <= magy_next;
        pt_b_reg <= pt_a_reg;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        pt_c_reg <= pt_b_reg;
        dist_reg <= dist_next;
    end

    assign out_tag  = tag_c_reg;
    assign out_pt   = pt_c_reg;
    assign out_dist = dist_reg;

endmodule

>>> rtl/nww_cell.sv
`timescale 1ns / 1ps

module nww_cell (
    input  logic                clk,
    input  nww_pkg::cell_ctl_t  ctl,
    input  nww_pkg::point_t     stream_pt,
    input  nww_pkg::point_t     nbr_pt,
    output nww_pkg::point_t     pt
);

    nww_pkg::point_t pt_reg;
    nww_pkg::point_t pt_next;

    always_comb
    begin
        pt_next = pt_reg;
        if (ctl.capture)
        begin
            pt_next = stream_pt;
        end
        else if (ctl.shift)
        begin
            pt_next = nbr_pt;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign pt = pt_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import nww_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int TABLE_SOFT_LIMIT = 48;
    localparam int BURST_ITEMS = 4;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } request_t;

    typedef struct packed {
        logic                 last;
        logic                 none_found;
        logic [OUT_IDX_W-1:0] idx;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   x;
    } waypoint_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    // path table as the block should hold it, updated on accepted requests
    logic [COORD_W-1:0] path_x [MAX_POINTS];
    logic [COORD_W-1:0] path_y [MAX_POINTS];
    int                 path_len = 0;
    int                 window_cfg = WL_RESET;

    // path table as planned by the stimulus, used to aim queries at stored points
    logic [COORD_W-1:0] plan_x [MAX_POINTS];
    logic [COORD_W-1:0] plan_y [MAX_POINTS];
    int                 plan_len = 0;

    request_t  request_q [$];
    waypoint_t waypoint_q [$];
    int        error_count = 0;
    bit        idle_on = 1'b0;
    bit        req_fire = 1'b0;
    int        send_gap = 0;
    int        recv_stall = 0;
    int        cycle_count = 0;

    nearest_waypoint_window u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // squared difference along one axis, exact
    function automatic logic [2*COORD_W+1:0] axis_sq(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        logic [COORD_W:0] diff;
        logic [COORD_W:0] mag;
        diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        mag = diff[COORD_W] ? -diff : diff;
        return {{(COORD_W+1){1'b0}}, mag} * {{(COORD_W+1){1'b0}}, mag};
    endfunction

    function automatic void predict_waypoints(input request_t rq);
        logic [2*COORD_W+1:0] sq_sum;
        logic [2*COORD_W+1:0] best_dist;
        int                   best;
        int                   win;
        int                   stop;
        int                   i;
        waypoint_t            wp;
        best = 0;
        best_dist = '0;
        if (rq.kind == KIND_CLEAR)
        begin
            path_len = 0;
        end
        else if (rq.kind == KIND_APPEND)
        begin
            // a full table drops the point
            if (path_len < MAX_POINTS)
            begin
                path_x[path_len] = rq.x;
                path_y[path_len] = rq.y;
                path_len++;
            end
        end
        else if (rq.kind == KIND_QUERY)
        begin
            if (path_len == 0)
            begin
                wp = '0;
                wp.none_found = 1'b1;
                wp.last = 1'b1;
                waypoint_q = {waypoint_q, wp};
            end
            else
            begin
                for (i = 0; i < path_len; i++)
                begin
                    sq_sum = axis_sq(path_x[i], rq.x) + axis_sq(path_y[i], rq.y);
                    // strict compare keeps the lowest index on a tie
                    if (i == 0 || sq_sum < best_dist)
                    begin
                        best = i;
                        best_dist = sq_sum;
                    end
                end
                win = (window_cfg == 0) ? 1 : window_cfg;
                if (win > MAX_WINDOW)
                    win = MAX_WINDOW;
                stop = (best + win > path_len) ? path_len : best + win;
                for (i = best; i < stop; i++)
                begin
                    wp.x = path_x[i];
                    wp.y = path_y[i];
                    wp.idx = i[OUT_IDX_W-1:0];
                    wp.none_found = 1'b0;
                    wp.last = (i + 1 == stop);
                    waypoint_q = {waypoint_q, wp};
                end
            end
        end
    endfunction

    // monitor: predict on accepted requests, then check accepted results
    always @(posedge clk)
    begin
        request_t  rq;
        waypoint_t got;
        waypoint_t want;
        req_fire = s_tvalid && s_tready;
        if (req_fire)
        begin
            rq.kind = s_tuser;
            rq.x = s_tdata[31:0];
            rq.y = s_tdata[63:32];
            predict_waypoints(rq);
        end
        if (m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tuser[0], m_tdata[71:64], m_tdata[63:32], m_tdata[31:0]};
            if (waypoint_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual x=%h y=%h idx=%0d",
                         $time, got.x, got.y, got.idx);
            end
            else
            begin
                want = waypoint_q.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch expected x=%h y=%h idx=%0d none=%b last=%b",
                             $time, want.x, want.y, want.idx, want.none_found, want.last);
                    $display("%0t:          actual   x=%h y=%h idx=%0d none=%b last=%b",
                             $time, got.x, got.y, got.idx, got.none_found, got.last);
                end
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        request_t rq;
        if (!s_tvalid || req_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                rq = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= rq.kind;
                s_tdata <= {rq.y, rq.x};
                if (idle_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random backpressure
    always @(negedge clk)
    begin
        if (recv_stall > 0)
        begin
            recv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
                recv_stall = $urandom_range(1, 19);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_request(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y);
        request_t rq;
        rq.kind = kind;
        rq.x = x;
        rq.y = y;
        request_q = {request_q, rq};
        if (kind == KIND_CLEAR)
        begin
            plan_len = 0;
        end
        else if (kind == KIND_APPEND && plan_len < MAX_POINTS)
        begin
            plan_x[plan_len] = x;
            plan_y[plan_len] = y;
            plan_len++;
        end
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            4: return ($urandom_range(0, 16) - 32'd8) << 16;
            default: return $urandom_range(0, 16) - 32'd8;
        endcase
    endfunction

    task automatic add_random_requests(input int count);
        int                 n;
        int                 pick;
        int                 j;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6 || (plan_len >= TABLE_SOFT_LIMIT && pick < 50))
            begin
                push_request(KIND_CLEAR, $urandom, $urandom);
            end
            else if (pick < 12)
            begin
                push_request(KIND_RESERVED, $urandom, $urandom);
            end
            else if (pick < 55)
            begin
                push_request(KIND_APPEND, rand_coord(), rand_coord());
            end
            else if (plan_len > 0 && $urandom_range(0, 1) == 0)
            begin
                // aim close to a stored point
                j = $urandom_range(0, plan_len - 1);
                qx = plan_x[j] + $urandom_range(0, 6) - 32'd3;
                qy = plan_y[j] + $urandom_range(0, 6) - 32'd3;
                push_request(KIND_QUERY, qx, qy);
            end
            else
            begin
                push_request(KIND_QUERY, rand_coord(), rand_coord());
            end
        end
    endtask

    // hold until every request is taken and every result has arrived
    task automatic settle();
        while (request_q.size() != 0 || s_tvalid || waypoint_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        window_cfg = int'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] windows [6];
        int               p;
        int               i;
        windows[0] = 6'd0;
        windows[1] = 6'd1;
        windows[2] = 6'd63;
        windows[3] = 6'd33;
        windows[4] = CFG_W'($urandom_range(2, 31));
        windows[5] = 6'd31;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset window length
        push_request(KIND_QUERY, 32'h0, 32'h0);
        push_request(KIND_RESERVED, 32'hffff_ffff, 32'hffff_ffff);
        push_request(KIND_APPEND, 32'h8000_0000, 32'h8000_0000);
        push_request(KIND_APPEND, 32'h7fff_ffff, 32'h7fff_ffff);
        push_request(KIND_APPEND, 32'h0, 32'h0);
        push_request(KIND_APPEND, 32'h8000_0000, 32'h7fff_ffff);
        push_request(KIND_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        push_request(KIND_APPEND, 32'h0, 32'h0);
        push_request(KIND_QUERY, 32'h7fff_ffff, 32'h7fff_ffff);
        push_request(KIND_QUERY, 32'h8000_0000, 32'h8000_0000);
        push_request(KIND_QUERY, 32'h0, 32'h0);
        push_request(KIND_QUERY, 32'h7fff_ffff, 32'h8000_0000);
        push_request(KIND_QUERY, 32'h1, 32'hffff_ffff);
        push_request(KIND_RESERVED, 32'h0, 32'h0);
        push_request(KIND_CLEAR, 32'h0, 32'h0);
        push_request(KIND_QUERY, 32'h1234_5678, 32'h8765_4321);
        push_request(KIND_APPEND, 32'h1234_5678, 32'hffff_fffb);
        push_request(KIND_QUERY, 32'h8000_0000, 32'h7fff_ffff);
        push_request(KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        settle();

        for (p = 0; p < 6; p++)
        begin
            write_window(windows[p]);
            idle_on = (p != 3);
            add_random_requests(BURST_ITEMS);
            settle();
        end

        // fill the table to the top, one append past full, then query across it
        write_window(6'd32);
        idle_on = 1'b1;
        push_request(KIND_CLEAR, 32'h0, 32'h0);
        for (i = 0; i < MAX_POINTS; i++)
            push_request(KIND_APPEND, (i - 128) << 24, $urandom);
        push_request(KIND_APPEND, $urandom, $urandom);
        push_request(KIND_QUERY, plan_x[MAX_POINTS-1], plan_y[MAX_POINTS-1]);
        push_request(KIND_QUERY, plan_x[0], plan_y[0]);
        push_request(KIND_QUERY, plan_x[240], plan_y[240]);
        push_request(KIND_QUERY, $urandom, $urandom);
        push_request(KIND_CLEAR, 32'h0, 32'h0);
        settle();

        // last stretch runs with no idling on either side
        idle_on = 1'b0;
        write_window(CFG_W'($urandom_range(1, 63)));
        add_random_requests(BURST_ITEMS);
        settle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
